@@ rtl/gjl_pkg.sv @@
// ----------------------------------------------------------------------------
// gjl_pkg
// Shared widths, codes and item types of the grid jump lookup block.
// ----------------------------------------------------------------------------
package gjl_pkg;

  localparam int CELL_W     = 14;
  localparam int STEP_W     = 15;
  localparam int LABEL_W    = 16;
  localparam int DIR_BITS   = 3;
  localparam int CFG_W      = 15;
  localparam int CFG_IDX_W  = 2;
  localparam int STRIDE_W   = CFG_W + 1;
  localparam int PROD_W     = STRIDE_W + STEP_W;
  localparam int ADDR_W     = 32;

  localparam int MAX_CELLS  = 16384;
  localparam int DIRS       = 8;
  localparam int MEM_DEPTH  = MAX_CELLS * DIRS;
  localparam int MEM_AW     = $clog2(MEM_DEPTH);

  localparam int DIV_STAGES = CELL_W;
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

  typedef logic [DIR_BITS-1:0] dir_t;

  localparam dir_t DIR_N  = 3'd0;
  localparam dir_t DIR_S  = 3'd1;
  localparam dir_t DIR_E  = 3'd2;
  localparam dir_t DIR_W  = 3'd3;
  localparam dir_t DIR_NE = 3'd4;
  localparam dir_t DIR_NW = 3'd5;
  localparam dir_t DIR_SE = 3'd6;
  localparam dir_t DIR_SW = 3'd7;

  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_ROW_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CELL_TOTAL = 2'd2;

  typedef struct packed {
    logic               func;
    logic [CELL_W-1:0]  cell_id;
    dir_t               dir;
    logic [CELL_W-1:0]  goal;
    logic [LABEL_W-1:0] label;
  } item_t;

  // Classified item handed from the front to the back.
  typedef struct packed {
    logic                func;
    logic [CELL_W-1:0]   cell_id;
    dir_t                dir;
    logic [CELL_W-1:0]   goal;
    logic [LABEL_W-1:0]  label;
    logic                gok;
    logic [CELL_W-1:0]   gdelta;
    logic [CELL_W-1:0]   rowdist;
    logic                same_col;
    logic                diag_ok;
    logic [CELL_W-1:0]   k;
    logic [CELL_W-1:0]   rem;
    logic [STRIDE_W-1:0] stride;
    logic [CELL_W-1:0]   mid;
    logic                mid_oob;
    dir_t                sdir;
  } job_t;

  typedef struct packed {
    logic              valid;
    logic [CELL_W-1:0] jump_cell;
    logic              dead_end;
    logic              goal_hit;
    logic [STEP_W-1:0] diagonal_steps;
    logic [STEP_W-1:0] straight_steps;
  } res_t;

endpackage

@@ rtl/gjl_div_pipe.sv @@
// ----------------------------------------------------------------------------
// gjl_div_pipe
// Pipelined restoring divider: one quotient bit per stage.
// ----------------------------------------------------------------------------
module gjl_div_pipe (
  input  logic                       clk,
  input  logic [gjl_pkg::CELL_W-1:0] dividend,
  input  logic [gjl_pkg::CFG_W-1:0]  divisor,
  output logic [gjl_pkg::CELL_W-1:0] quotient,
  output logic [gjl_pkg::CELL_W-1:0] remainder
);
  import gjl_pkg::*;

  logic [CFG_W-1:0]  rem_r [DIV_STAGES];
  logic [CELL_W-1:0] quo_r [DIV_STAGES];
  logic [CELL_W-1:0] dvd_r [DIV_STAGES-1];

  for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
    logic [CFG_W-1:0]  rem_in;
    logic [CELL_W-1:0] quo_in;
    logic [CELL_W-1:0] dvd_in;
    logic [CFG_W:0]    trial;
    logic [CFG_W:0]    diff;
    logic              ge;

    if (s == 0) begin : g_first
      assign rem_in = '0;
      assign quo_in = '0;
      assign dvd_in = dividend;
    end else begin : g_next
      assign rem_in = rem_r[s-1];
      assign quo_in = quo_r[s-1];
      assign dvd_in = dvd_r[s-1];
    end

    assign trial = {rem_in, dvd_in[CELL_W-1-s]};
    assign ge    = trial >= {1'b0, divisor};
    assign diff  = trial - {1'b0, divisor};

    always_ff @(posedge clk) begin
      rem_r[s] <= ge ? diff[CFG_W-1:0] : trial[CFG_W-1:0];
      quo_r[s] <= {quo_in[CELL_W-2:0], ge};
    end

    if (s < DIV_STAGES - 1) begin : g_carry
      always_ff @(posedge clk) begin
        dvd_r[s] <= dvd_in;
      end
    end
  end

  assign quotient  = quo_r[DIV_STAGES-1];
  assign remainder = rem_r[DIV_STAGES-1][CELL_W-1:0];

endmodule

@@ rtl/gjl_front.sv @@
// ----------------------------------------------------------------------------
// gjl_front
// Takes items, splits cell ids into row and column, and classifies queries.
// ----------------------------------------------------------------------------
module gjl_front (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       acc,
  input  gjl_pkg::item_t             item,
  input  logic [gjl_pkg::CFG_W-1:0]  w_eff,
  input  logic [gjl_pkg::CFG_W-1:0]  row_count,
  input  logic [gjl_pkg::CFG_W-1:0]  cell_total,
  output logic                       push,
  output gjl_pkg::job_t              job
);
  import gjl_pkg::*;

  item_t             item_r;
  logic              vld_r;
  item_t             pay_r [DIV_STAGES];
  logic              pv_r  [DIV_STAGES];
  logic [CELL_W-1:0] qn, rn, qg, rg;

  job_t              c1_r, c1_nxt;
  logic              c1v_r;
  job_t              job_r, job_nxt;
  logic              push_r;

  always_ff @(posedge clk) begin
    item_r <= item;
    pay_r[0] <= item_r;
    for (int i = 1; i < DIV_STAGES; i++) pay_r[i] <= pay_r[i-1];
    if (!rst_n) begin
      vld_r <= 1'b0;
      for (int i = 0; i < DIV_STAGES; i++) pv_r[i] <= 1'b0;
    end else begin
      vld_r <= acc;
      pv_r[0] <= vld_r;
      for (int i = 1; i < DIV_STAGES; i++) pv_r[i] <= pv_r[i-1];
    end
  end

  gjl_div_pipe u_div_node (
    .clk(clk), .dividend(item_r.cell_id), .divisor(w_eff), .quotient(qn), .remainder(rn)
  );

  gjl_div_pipe u_div_goal (
    .clk(clk), .dividend(item_r.goal), .divisor(w_eff), .quotient(qg), .remainder(rg)
  );

  // Classify: straight reach data and diagonal turn point.
  always_comb begin
    item_t             p;
    logic              fwd, north, east, horiz, span_ok;
    logic [CELL_W:0]   gd, span, yd, xd;
    logic [CELL_W-1:0] xs, ys;
    p       = pay_r[DIV_STAGES-1];
    fwd     = (p.dir == DIR_S) || (p.dir == DIR_E);
    north   = (p.dir == DIR_NE) || (p.dir == DIR_NW);
    east    = (p.dir == DIR_NE) || (p.dir == DIR_SE);
    gd      = fwd ? {1'b0, p.goal} - {1'b0, p.cell_id} : {1'b0, p.cell_id} - {1'b0, p.goal};
    span    = north ? {1'b0, p.cell_id} - {1'b0, p.goal} : {1'b0, p.goal} - {1'b0, p.cell_id};
    yd      = north ? {1'b0, qn} - {1'b0, qg} : {1'b0, qg} - {1'b0, qn};
    xd      = east ? {1'b0, rg} - {1'b0, rn} : {1'b0, rn} - {1'b0, rg};
    xs      = xd[CELL_W-1:0];
    ys      = yd[CELL_W-1:0];
    span_ok = !span[CELL_W] && (span < cell_total);
    horiz   = ys < xs;

    c1_nxt          = '0;
    c1_nxt.func     = p.func;
    c1_nxt.cell_id  = p.cell_id;
    c1_nxt.dir      = p.dir;
    c1_nxt.goal     = p.goal;
    c1_nxt.label    = p.label;
    c1_nxt.gok      = !gd[CELL_W];
    c1_nxt.gdelta   = gd[CELL_W-1:0];
    c1_nxt.rowdist  = fwd ? qg - qn : qn - qg;
    c1_nxt.same_col = rn == rg;
    c1_nxt.diag_ok  = span_ok && !xd[CELL_W] && !yd[CELL_W] && (xd < w_eff)
                      && (yd < row_count);
    c1_nxt.k        = horiz ? ys : xs;
    c1_nxt.rem      = horiz ? xs - ys : ys - xs;
    c1_nxt.stride   = (north == east) ? {1'b0, w_eff} - STRIDE_W'(1)
                                      : {1'b0, w_eff} + STRIDE_W'(1);
    c1_nxt.sdir     = horiz ? (east ? DIR_E : DIR_W) : (north ? DIR_N : DIR_S);
  end

  // Turn point cell: start moved k diagonal steps; flag it when past the store.
  always_comb begin
    logic [STRIDE_W+CELL_W-1:0] prod;
    logic [STRIDE_W+CELL_W:0]   mid_full;
    logic                       north;
    prod     = c1_r.stride * c1_r.k;
    north    = (c1_r.dir == DIR_NE) || (c1_r.dir == DIR_NW);
    mid_full = north ? {{(STRIDE_W+1){1'b0}}, c1_r.cell_id} - {1'b0, prod}
                     : {{(STRIDE_W+1){1'b0}}, c1_r.cell_id} + {1'b0, prod};
    job_nxt  = c1_r;
    job_nxt.mid     = mid_full[CELL_W-1:0];
    job_nxt.mid_oob = |mid_full[STRIDE_W+CELL_W:CELL_W];
  end

  always_ff @(posedge clk) begin
    c1_r  <= c1_nxt;
    job_r <= job_nxt;
    if (!rst_n) begin
      c1v_r  <= 1'b0;
      push_r <= 1'b0;
    end else begin
      c1v_r  <= pv_r[DIV_STAGES-1];
      push_r <= c1v_r;
    end
  end

  assign push = push_r;
  assign job  = job_r;

endmodule

@@ rtl/gjl_queue.sv @@
// ----------------------------------------------------------------------------
// gjl_queue
// Short FIFO between the front and the back.
// ----------------------------------------------------------------------------
module gjl_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  gjl_pkg::job_t din,
  input  logic          pop,
  output logic          head_valid,
  output gjl_pkg::job_t dout,
  output logic          full
);
  import gjl_pkg::*;

  job_t                slot_r [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wp_r, rp_r;
  logic [QUEUE_AW:0]   cnt_r;
  logic                do_pop;

  assign do_pop     = pop && (cnt_r != '0);
  assign head_valid = cnt_r != '0;
  assign dout       = slot_r[rp_r];
  assign full       = cnt_r == (QUEUE_AW+1)'(QUEUE_DEPTH);

  always_ff @(posedge clk) begin
    if (push && !full) slot_r[wp_r] <= din;
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push && !full) wp_r <= wp_r + 1'b1;
      if (do_pop) rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + (QUEUE_AW+1)'(push && !full) - (QUEUE_AW+1)'(do_pop);
    end
  end

endmodule

@@ rtl/gjl_back.sv @@
// ----------------------------------------------------------------------------
// gjl_back
// Label memory, both label reads, and the jump and cost resolution.
// ----------------------------------------------------------------------------
module gjl_back (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      beat,
  input  gjl_pkg::job_t             job,
  input  logic [gjl_pkg::CFG_W-1:0] w_eff,
  output gjl_pkg::res_t             res
);
  import gjl_pkg::*;

  logic [LABEL_W-1:0] mem [MEM_DEPTH];
  logic [LABEL_W-1:0] rda_r, rdb_r;
  job_t               j1_r, j2_r;
  logic               v1_r, v2_r;
  logic [PROD_W-1:0]  p_r, p_nxt;
  logic               dhit_r, dhit_nxt;
  logic               dead1_r;
  logic [STEP_W-1:0]  steps1_r;
  res_t               res_r, res_nxt;

  // Write and both reads at one stage keep item order.
  always_ff @(posedge clk) begin
    if (beat && job.func == FUNC_WRITE) mem[{job.cell_id, job.dir}] <= job.label;
    rda_r <= mem[{job.cell_id, job.dir}];
    rdb_r <= mem[{job.mid, job.sdir}];
    j1_r  <= job;
  end

  always_comb begin
    logic [STRIDE_W-1:0] mult_a;
    logic [STEP_W-1:0]   s1, s2;
    logic                vert;
    s1     = rda_r[STEP_W-1:0];
    // a turn point past the store reads as an empty label
    s2     = j1_r.mid_oob ? '0 : rdb_r[STEP_W-1:0];
    vert   = (j1_r.dir == DIR_N) || (j1_r.dir == DIR_S);
    mult_a = !j1_r.dir[DIR_BITS-1] ? (vert ? {1'b0, w_eff} : STRIDE_W'(1)) : j1_r.stride;
    p_nxt  = mult_a * s1;
    dhit_nxt = j1_r.diag_ok && ({1'b0, j1_r.k} <= s1) && (s2 >= {1'b0, j1_r.rem});
  end

  always_comb begin
    logic              straight, vert, fwd, north, sub, hit_s, dead;
    logic [ADDR_W-1:0] jn;
    straight = !j2_r.dir[DIR_BITS-1];
    vert     = (j2_r.dir == DIR_N) || (j2_r.dir == DIR_S);
    fwd      = (j2_r.dir == DIR_S) || (j2_r.dir == DIR_E);
    north    = (j2_r.dir == DIR_NE) || (j2_r.dir == DIR_NW);
    sub      = straight ? !fwd : north;
    hit_s    = j2_r.gok && (p_r >= PROD_W'(j2_r.gdelta)) && (!vert || j2_r.same_col);
    jn       = sub ? ADDR_W'(j2_r.cell_id) - ADDR_W'(p_r)
                   : ADDR_W'(j2_r.cell_id) + ADDR_W'(p_r);
    res_nxt  = '0;
    res_nxt.valid = v2_r;
    dead     = dead1_r;
    if (straight) begin
      res_nxt.straight_steps = steps1_r;
      if (hit_s) begin
        jn   = ADDR_W'(j2_r.goal);
        dead = 1'b0;
        res_nxt.straight_steps = STEP_W'(vert ? j2_r.rowdist : j2_r.gdelta);
      end
    end else begin
      res_nxt.diagonal_steps = steps1_r;
      if (dhit_r) begin
        jn   = ADDR_W'(j2_r.goal);
        dead = 1'b0;
        res_nxt.diagonal_steps = STEP_W'(j2_r.k);
        res_nxt.straight_steps = STEP_W'(j2_r.rem);
      end
    end
    res_nxt.dead_end  = dead;
    res_nxt.goal_hit  = !dead && (jn == ADDR_W'(j2_r.goal));
    res_nxt.jump_cell = dead ? '0 : jn[CELL_W-1:0];
  end

  always_ff @(posedge clk) begin
    j2_r     <= j1_r;
    p_r      <= p_nxt;
    dhit_r   <= dhit_nxt;
    dead1_r  <= rda_r[LABEL_W-1];
    steps1_r <= rda_r[STEP_W-1:0];
    if (!rst_n) begin
      v1_r  <= 1'b0;
      v2_r  <= 1'b0;
      res_r <= '0;
    end else begin
      v1_r  <= beat && job.func == FUNC_QUERY;
      v2_r  <= v1_r;
      res_r <= res_nxt;
    end
  end

  assign res = res_r;

endmodule

@@ rtl/precomputed_grid_jump_lookup_top.sv @@
// ----------------------------------------------------------------------------
// precomputed_grid_jump_lookup_top
// Jump point label store with straight and diagonal jump queries.
// ----------------------------------------------------------------------------
// Usage:
//   Input: drive in_* and raise start; the item is taken on a clock edge
//   where start is high and busy is low. func 0 writes one label at
//   (cell_id, direction); func 1 asks a jump query.
//   Output: each query gives one result, on out_* for one cycle with
//   out_valid high. Writes give no result.
//   Throughput: one item per cycle while busy is low; the front divides
//   cell ids by the row width in a 14-stage pipelined divider, the back reads
//   both labels of a query at once from a dual-read label memory, so nothing
//   recirculates. Results cannot be held off; the back never stalls.
//   Config: cfg_valid/cfg_ready with cfg_index 0 row width, 1 row count,
//   2 cell total; write only while no query is in flight.
//   Reset: registers return to 128/128/16384 and the pipeline empties.
//   The label memory is not cleared; write every label before it is read.
// ----------------------------------------------------------------------------
module precomputed_grid_jump_lookup_top (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic                          in_func,
  input  logic [gjl_pkg::CELL_W-1:0]    in_cell_id,
  input  logic [gjl_pkg::DIR_BITS-1:0]  in_direction,
  input  logic [gjl_pkg::CELL_W-1:0]    in_goal_cell,
  input  logic [gjl_pkg::LABEL_W-1:0]   in_label_word,
  output logic                          out_valid,
  output logic [gjl_pkg::CELL_W-1:0]    out_jump_cell,
  output logic                          out_dead_end,
  output logic                          out_goal_hit,
  output logic [gjl_pkg::STEP_W-1:0]    out_diagonal_steps,
  output logic [gjl_pkg::STEP_W-1:0]    out_straight_steps,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [gjl_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [gjl_pkg::CFG_W-1:0]     cfg_data
);
  import gjl_pkg::*;

  logic [CFG_W-1:0] row_width_r, row_count_r, cell_total_r;
  logic [CFG_W-1:0] w_eff;
  logic             acc, push, head_valid, full;
  item_t            item;
  job_t             fjob, qjob;
  res_t             res;

  assign cfg_ready = 1'b1;
  assign busy      = full;
  assign acc       = start && !busy;
  assign w_eff     = (row_width_r == '0) ? CFG_W'(1) : row_width_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_width_r  <= CFG_W'(128);
      row_count_r  <= CFG_W'(128);
      cell_total_r <= CFG_W'(MAX_CELLS);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_ROW_WIDTH:  row_width_r  <= cfg_data;
        REG_ROW_COUNT:  row_count_r  <= cfg_data;
        REG_CELL_TOTAL: cell_total_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    item.func    = in_func;
    item.cell_id = in_cell_id;
    item.dir     = in_direction;
    item.goal    = in_goal_cell;
    item.label   = in_label_word;
  end

  gjl_front u_front (
    .clk(clk), .rst_n(rst_n), .acc(acc), .item(item), .w_eff(w_eff),
    .row_count(row_count_r), .cell_total(cell_total_r), .push(push), .job(fjob)
  );

  gjl_queue u_queue (
    .clk(clk), .rst_n(rst_n), .push(push), .din(fjob), .pop(1'b1),
    .head_valid(head_valid), .dout(qjob), .full(full)
  );

  gjl_back u_back (
    .clk(clk), .rst_n(rst_n), .beat(head_valid), .job(qjob), .w_eff(w_eff), .res(res)
  );

  assign out_valid          = res.valid;
  assign out_jump_cell      = res.jump_cell;
  assign out_dead_end       = res.dead_end;
  assign out_goal_hit       = res.goal_hit;
  assign out_diagonal_steps = res.diagonal_steps;
  assign out_straight_steps = res.straight_steps;

endmodule
